// ----- sv/ucpb_pkg.sv -----
// ----------------------------------------------------------------------------
// ucpb_pkg
// Shared types and constants of the unique color palette builder: palette
// geometry, stream field widths, opcodes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ucpb_pkg;

    // palette geometry
    localparam int PALETTE_SLOTS = 256;
    localparam int SLOT_W        = $clog2(PALETTE_SLOTS);
    localparam int CNT_W         = $clog2(PALETTE_SLOTS + 1);

    // field widths fixed by the stream format
    localparam int CHAN_W        = 8;
    localparam int COLOR_W       = 3 * CHAN_W;
    localparam int SEL_W         = 8;
    localparam int SLOT_OUT_W    = 8;
    localparam int USED_W        = 9;
    localparam int OP_W          = 2;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_FIELDS_W  = SLOT_OUT_W + USED_W + 4 * CHAN_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W   = 2;

    // alpha codes
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    // item kinds
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_RDMEM  = 6'b000100,
        S_DIV    = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic scan;
        logic rd;
        logic fill;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic found;
        logic exhausted;
        logic div_done;
        logic fill_last;
        logic out_free;
    } t_status;

endpackage

// ----- sv/ucpb_div.sv -----
// ----------------------------------------------------------------------------
// ucpb_div
// Restoring divider, one quotient bit per cycle, used for the gray step.
// ----------------------------------------------------------------------------
module ucpb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ucpb_pkg::CNT_W-1:0] i_dividend,
    input  logic [ucpb_pkg::CNT_W-1:0] i_divisor,
    output logic [ucpb_pkg::CNT_W-1:0] o_quotient,
    output logic                       o_done
);

    localparam int W      = ucpb_pkg::CNT_W;
    localparam int STEP_W = $clog2(W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_quo;
    logic [W-1:0]      r_dvs;
    logic [W:0]        rem_sh;
    logic [W:0]        diff;

    // trial subtraction of one step
    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~diff[W]};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ----- sv/ucpb_dp.sv -----
// ----------------------------------------------------------------------------
// ucpb_dp
// Datapath: palette memory, fill count, search pipeline, gray fill, divider
// and the output register of the result stream.
// ----------------------------------------------------------------------------
module ucpb_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ucpb_pkg::t_cmd                   i_cmd,
    output ucpb_pkg::t_status                o_status,
    input  ucpb_pkg::t_opcode                i_opcode,
    input  logic [ucpb_pkg::CHAN_W-1:0]      i_red,
    input  logic [ucpb_pkg::CHAN_W-1:0]      i_green,
    input  logic [ucpb_pkg::CHAN_W-1:0]      i_blue,
    input  logic [ucpb_pkg::SEL_W-1:0]       i_entry_select,
    input  logic                             i_m_ready,
    output logic                             o_m_valid,
    output logic [ucpb_pkg::OUT_TDATA_W-1:0] o_m_data,
    output logic [ucpb_pkg::OUT_TUSER_W-1:0] o_m_user
);

    localparam int SLOTS   = ucpb_pkg::PALETTE_SLOTS;
    localparam int SLOT_W  = ucpb_pkg::SLOT_W;
    localparam int CNT_W   = ucpb_pkg::CNT_W;
    localparam int CHAN_W  = ucpb_pkg::CHAN_W;
    localparam int COLOR_W = ucpb_pkg::COLOR_W;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(SLOTS - 1);

    logic [COLOR_W-1:0] mem [SLOTS];

    // item and result state
    ucpb_pkg::t_opcode                  r_op;
    logic [COLOR_W-1:0]                 r_color;
    logic [ucpb_pkg::SEL_W-1:0]         r_sel;
    logic [CNT_W-1:0]                   r_idx;
    logic [SLOT_W-1:0]                  r_cmp_idx;
    logic                               r_cmp_vld;
    logic [COLOR_W-1:0]                 r_rd_data;
    logic [CHAN_W-1:0]                  r_shade;
    logic [CHAN_W-1:0]                  r_gray;
    logic [ucpb_pkg::SLOT_OUT_W-1:0]    r_res_slot;
    logic                               r_res_new;
    logic                               r_res_full;
    logic [CNT_W-1:0]                   r_fill_count;
    logic                               r_finished;
    logic                               r_m_valid;
    logic [ucpb_pkg::OUT_TDATA_W-1:0]   r_m_data;
    logic [ucpb_pkg::OUT_TUSER_W-1:0]   r_m_user;

    logic [CNT_W-1:0]   lim;
    logic               issue;
    logic               full;
    logic               found;
    logic               exhausted;
    logic               append;
    logic [CHAN_W-1:0]  gray_next;
    logic [SLOT_W-1:0]  fill_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic [CNT_W-1:0]   sel_ext;
    logic               sel_in_range;
    logic               rd_ok;
    logic [COLOR_W-1:0] out_color;
    logic [CHAN_W-1:0]  out_alpha;
    logic [CNT_W-1:0]   div_quo;
    logic               div_done;

    // search bounds; the transparent last slot is skipped after finish
    always_comb begin
        full      = (r_fill_count >= SLOTS_C);
        lim       = r_finished ? LAST_C : r_fill_count;
        issue     = i_cmd.scan && (r_idx < lim);
        found     = r_cmp_vld && (r_rd_data == r_color);
        exhausted = !r_cmp_vld && !(r_idx < lim);
        append    = i_cmd.scan && !found && exhausted && !full;
    end

    // gray fill address and value
    always_comb begin
        gray_next = r_gray + r_shade;
        fill_addr = (r_idx >= LAST_C) ? SLOT_W'(SLOTS - 1) : r_idx[SLOT_W-1:0];
    end

    // memory port selection
    always_comb begin
        wr_en   = append || i_cmd.fill;
        wr_addr = append ? r_fill_count[SLOT_W-1:0] : fill_addr;
        if (append) begin
            wr_data = r_color;
        end else if (fill_addr == SLOT_W'(SLOTS - 1)) begin
            wr_data = '0;
        end else begin
            wr_data = {gray_next, gray_next, gray_next};
        end
        rd_en   = issue || i_cmd.rd;
        rd_addr = i_cmd.rd ? r_sel[SLOT_W-1:0] : r_idx[SLOT_W-1:0];
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // gray step division
    ucpb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (SLOTS_C),
        .i_divisor  (SLOTS_C - r_fill_count),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // fill count and finish flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count <= '0;
            r_finished   <= 1'b0;
        end else if (append) begin
            r_fill_count <= r_fill_count + CNT_W'(1);
        end else if (i_cmd.fill && (r_idx >= LAST_C)) begin
            r_fill_count <= SLOTS_C;
            r_finished   <= 1'b1;
        end
    end

    // item capture, search pipeline and fill walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_color    <= {i_red, i_green, i_blue};
            r_sel      <= i_entry_select;
            r_idx      <= (i_opcode == ucpb_pkg::OP_FINISH) ? r_fill_count : '0;
            r_cmp_vld  <= 1'b0;
            r_gray     <= '0;
            r_res_slot <= (i_opcode == ucpb_pkg::OP_READ) ? i_entry_select : '0;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end else begin
            if (i_cmd.scan) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_cmp_idx <= r_idx[SLOT_W-1:0];
                    r_idx     <= r_idx + CNT_W'(1);
                end
                if (found) begin
                    r_res_slot <= ucpb_pkg::SLOT_OUT_W'(r_cmp_idx);
                end else if (exhausted && !full) begin
                    r_res_slot <= ucpb_pkg::SLOT_OUT_W'(r_fill_count[SLOT_W-1:0]);
                    r_res_new  <= 1'b1;
                end else if (exhausted) begin
                    r_res_full <= 1'b1;
                end
            end
            if (i_cmd.fill) begin
                r_gray <= gray_next;
                r_idx  <= r_idx + CNT_W'(1);
            end
        end
        if (div_done) begin
            r_shade <= CHAN_W'(div_quo);
        end
    end

    // read result: unwritten slots above the fill count read as black
    always_comb begin
        sel_ext      = CNT_W'(r_sel);
        sel_in_range = (sel_ext < SLOTS_C);
        rd_ok        = sel_in_range && (sel_ext < r_fill_count);
        out_color    = '0;
        out_alpha    = '0;
        if (r_op == ucpb_pkg::OP_READ) begin
            out_color = rd_ok ? r_rd_data : '0;
            if (sel_in_range) begin
                out_alpha = (r_finished && (sel_ext == LAST_C)) ?
                            ucpb_pkg::ALPHA_CLEAR : ucpb_pkg::ALPHA_OPAQUE;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_data <= {{ucpb_pkg::OUT_PAD_W{1'b0}}, out_alpha,
                         out_color[CHAN_W-1:0], out_color[2*CHAN_W-1:CHAN_W],
                         out_color[COLOR_W-1:2*CHAN_W],
                         ucpb_pkg::USED_W'(r_fill_count), r_res_slot};
            r_m_user <= {r_res_full, r_res_new};
        end
    end

    always_comb begin
        o_status.full      = full;
        o_status.found     = found;
        o_status.exhausted = exhausted;
        o_status.div_done  = div_done;
        o_status.fill_last = (r_idx >= LAST_C);
        o_status.out_free  = !r_m_valid || i_m_ready;
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_user  = r_m_user;

endmodule

// ----- sv/ucpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ucpb_ctrl
// Controller: takes one item at a time, sequences search, read, division
// and gray fill, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ucpb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ucpb_pkg::t_opcode i_opcode,
    output logic              o_ready,
    input  ucpb_pkg::t_status i_status,
    output ucpb_pkg::t_cmd    o_cmd
);

    ucpb_pkg::t_state r_state;
    ucpb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucpb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ucpb_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        ucpb_pkg::OP_ADD: begin
                            n_state = ucpb_pkg::S_SEARCH;
                        end
                        ucpb_pkg::OP_FINISH: begin
                            if (i_status.full) begin
                                n_state = ucpb_pkg::S_FILL;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = ucpb_pkg::S_DIV;
                            end
                        end
                        ucpb_pkg::OP_READ: begin
                            n_state = ucpb_pkg::S_RDMEM;
                        end
                        default: begin
                            n_state = ucpb_pkg::S_RESULT;
                        end
                    endcase
                end
            end
            ucpb_pkg::S_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_status.found || i_status.exhausted) begin
                    n_state = ucpb_pkg::S_RESULT;
                end
            end
            ucpb_pkg::S_RDMEM: begin
                o_cmd.rd = 1'b1;
                n_state  = ucpb_pkg::S_RESULT;
            end
            ucpb_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = ucpb_pkg::S_FILL;
                end
            end
            ucpb_pkg::S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ucpb_pkg::S_RESULT;
                end
            end
            ucpb_pkg::S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ucpb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ucpb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/unique_color_palette_builder.sv -----
// ----------------------------------------------------------------------------
// unique_color_palette_builder
// Builds a palette of unique RGB colors from a pixel stream, fills the
// free slots with grays on finish and serves entry reads.
// ----------------------------------------------------------------------------
// One item is worked at a time, one result beat per item. In an add the
// stored colors are compared one per cycle through the single read port
// of the palette memory. A finish runs a 9-step restoring division for
// the gray step when the palette is not full, then one memory write per
// free slot. The output register lets the next item be taken while the
// last result waits. After reset no clearing pass runs: slots above the
// fill count read as opaque black.
module unique_color_palette_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // red[7:0], green[15:8], blue[23:16], entry_select[31:24]
    input  logic [ucpb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [ucpb_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot[7:0], used_count[16:8], out_red[24:17], out_green[32:25],
    // out_blue[40:33], out_alpha[48:41], zero[55:49]
    output logic [ucpb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // is_new[0], table_full[1]
    output logic [ucpb_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    ucpb_pkg::t_cmd    cmd;
    ucpb_pkg::t_status status;
    ucpb_pkg::t_opcode opcode;

    assign opcode = ucpb_pkg::t_opcode'(s_axis_tuser);

    ucpb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_opcode (opcode),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ucpb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_opcode       (opcode),
        .i_red          (s_axis_tdata[7:0]),
        .i_green        (s_axis_tdata[15:8]),
        .i_blue         (s_axis_tdata[23:16]),
        .i_entry_select (s_axis_tdata[31:24]),
        .i_m_ready      (m_axis_tready),
        .o_m_valid      (m_axis_tvalid),
        .o_m_data       (m_axis_tdata),
        .o_m_user       (m_axis_tuser)
    );

endmodule

// ----- sv/ucpb_checker.sv -----
// ----------------------------------------------------------------------------
// ucpb_checker
// Port-level checks of the palette builder result stream, bound to the top.
// ----------------------------------------------------------------------------
module ucpb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ucpb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [ucpb_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a beat is never both new and full
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("is_new and table_full both set");

    // full flag only with every slot used
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[16:8] == ucpb_pkg::USED_W'(ucpb_pkg::PALETTE_SLOTS))
        else $error("table_full with free slots");

    // an appended color lands on the last used slot
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[16:8] == ({1'b0, m_axis_tdata[7:0]} + 9'd1))
        else $error("new slot does not match used count");

endmodule

bind unique_color_palette_builder ucpb_checker u_ucpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
